### rtl/cwvg_pkg.sv
// Package: shared types, constants and tables for the circle waypoint velocity guide
`default_nettype none
package cwvg_pkg;

  localparam int CordicSteps = 18;
  localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;

  // Configuration register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_SPEED  = 2'd2;
  localparam logic [1:0] REG_REACH  = 2'd3;

  // Datapath operation codes
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture position, start of item
    OP_REACH,     // reach test on old target
    OP_ANGLE,     // advance angle, set up CORDIC
    OP_CORDIC,    // one CORDIC rotation
    OP_RMUL,      // radius times cos and sin
    OP_TARGET,    // form target
    OP_DIFF,      // difference vector
    OP_NORM,      // one normalizing shift
    OP_SQSUM,     // square sum
    OP_SQRT,      // one square root step
    OP_NUM,       // numerators
    OP_DIV,       // one divider step (both lanes)
    OP_FINISH     // sign, clamp, output
  } op_t;

  typedef struct packed {
    op_t op;
    logic do_adv;
  } cwvg_cmd_t;

  typedef struct packed {
    logic adv;       // advance decision
    logic degen;     // zero difference vector
    logic norm_done; // normalized
  } cwvg_sts_t;

  function automatic logic signed [23:0] atan_lut(input logic [4:0] i);
    logic signed [23:0] v;
    case (i)
      5'd0:  v = 24'sd2949120;
      5'd1:  v = 24'sd1740967;
      5'd2:  v = 24'sd919879;
      5'd3:  v = 24'sd466945;
      5'd4:  v = 24'sd234379;
      5'd5:  v = 24'sd117304;
      5'd6:  v = 24'sd58666;
      5'd7:  v = 24'sd29335;
      5'd8:  v = 24'sd14668;
      5'd9:  v = 24'sd7334;
      5'd10: v = 24'sd3667;
      5'd11: v = 24'sd1833;
      5'd12: v = 24'sd917;
      5'd13: v = 24'sd458;
      5'd14: v = 24'sd229;
      5'd15: v = 24'sd115;
      5'd16: v = 24'sd57;
      5'd17: v = 24'sd29;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/cwvg_ctrl.sv
// Controller: sequences the datapath through one item
`default_nettype none
module cwvg_ctrl import cwvg_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire cwvg_sts_t sts,
  output cwvg_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_REACH  = 4'd1;
  localparam logic [3:0] S_ANGLE  = 4'd2;
  localparam logic [3:0] S_CORDIC = 4'd3;
  localparam logic [3:0] S_RMUL   = 4'd4;
  localparam logic [3:0] S_TARGET = 4'd5;
  localparam logic [3:0] S_DIFF   = 4'd6;
  localparam logic [3:0] S_NORM   = 4'd7;
  localparam logic [3:0] S_SQSUM  = 4'd8;
  localparam logic [3:0] S_SQRT   = 4'd9;
  localparam logic [3:0] S_NUM    = 4'd10;
  localparam logic [3:0] S_DIV    = 4'd11;
  localparam logic [3:0] S_FINISH = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       adv_r, adv_nxt;

  assign out_valid = ovalid_r;
  // Accept a new item while the previous result still waits in the output register
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r;
    adv_nxt    = adv_r;
    cmd.op     = OP_NONE;
    cmd.do_adv = adv_r;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_REACH;
        end
      end
      S_REACH: begin
        cmd.op  = OP_REACH;
        adv_nxt = sts.adv;
        state_nxt = sts.adv ? S_ANGLE : S_DIFF;
      end
      S_ANGLE: begin
        cmd.op    = OP_ANGLE;
        cnt_nxt   = '0;
        state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.op  = OP_CORDIC;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(CordicSteps - 1)) state_nxt = S_RMUL;
      end
      S_RMUL: begin
        cmd.op    = OP_RMUL;
        state_nxt = S_TARGET;
      end
      S_TARGET: begin
        cmd.op    = OP_TARGET;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (sts.degen) state_nxt = S_FINISH;
        else if (sts.norm_done) state_nxt = S_SQSUM;
        else cmd.op = OP_NORM;
      end
      S_SQSUM: begin
        cmd.op    = OP_SQSUM;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) state_nxt = S_NUM;
      end
      S_NUM: begin
        cmd.op    = OP_NUM;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd52) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // Wait for the output register to drain
        if (!ovalid_r || out_ready) begin
          cmd.op     = OP_FINISH;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
      adv_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      adv_r    <= adv_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/cwvg_dp.sv
// Datapath: configuration, state, CORDIC, square root and divider
`default_nettype none
module cwvg_dp import cwvg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cwvg_cmd_t   cmd,
  output cwvg_sts_t        sts,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic        in_restart,
  output logic [20:0]      out_vel_x,
  output logic [20:0]      out_vel_y,
  output logic [8:0]       out_angle_deg,
  output logic             out_advanced,
  output logic             out_degenerate
);

  // Configuration
  logic [22:0] radius_r;
  logic [6:0]  step_r;
  logic [20:0] speed_r;
  logic [19:0] reach_r;

  // Persistent state
  logic signed [31:0] anchor_x_r, anchor_y_r, target_x_r, target_y_r;
  logic [8:0]  angle_r;
  logic        anchored_r;

  // Working registers
  logic signed [31:0] px_r, py_r;
  logic               restart_r;
  logic signed [33:0] cx_r, cy_r;      // CORDIC x, y in Q30
  logic signed [24:0] cz_r;
  logic               cneg_r;
  logic [4:0]         ci_r;
  logic signed [56:0] rc_r, rs_r;
  logic signed [32:0] dx_r, dy_r;
  logic [32:0]        mx_r, my_r;
  logic [63:0] sq_v_r, sq_res_r, sq_bit_r;
  logic [52:0] nx_r, ny_r;             // numerator / quotient lanes
  logic [31:0] rx_r, ry_r;             // remainders
  logic [31:0] len_r;
  logic        degen_r;

  // Combinational helpers
  logic [32:0] ax, ay;
  logic [40:0] sum2;
  logic [40:0] th2;
  logic        adv_c;
  logic [9:0]  ang_sum;
  logic [8:0]  ang_new;
  logic signed [9:0] fold;
  logic        fold_neg;
  logic signed [33:0] shx, shy;
  logic signed [23:0] at;
  logic [32:0] mmax;
  logic [63:0] sq_trial;
  logic [20:0] spm;
  logic signed [34:0] tx_w, ty_w;
  logic [32:0] rx_t, ry_t;
  logic signed [22:0] vx_w, vy_w;
  logic signed [20:0] sp_s;

  assign sp_s = speed_r;
  assign spm  = sp_s[20] ? 21'(-sp_s) : speed_r;

  // Reach test on old target
  always_comb begin
    logic signed [32:0] ddx, ddy;
    ddx = 33'(signed'(px_r)) - 33'(signed'(target_x_r));
    ddy = 33'(signed'(py_r)) - 33'(signed'(target_y_r));
    ax  = ddx[32] ? 33'(-ddx) : 33'(ddx);
    ay  = ddy[32] ? 33'(-ddy) : 33'(ddy);
    th2 = 41'(reach_r) * 41'(reach_r);
    sum2 = 41'(ax[19:0]) * 41'(ax[19:0]) + 41'(ay[19:0]) * 41'(ay[19:0]);
    adv_c = !anchored_r || restart_r ||
            (ax < 33'(reach_r) && ay < 33'(reach_r) && sum2 < th2);
  end

  // Angle advance with wrap, and fold into -90..90
  always_comb begin
    ang_sum  = 10'(angle_r) + 10'(step_r);
    ang_new  = (ang_sum > 10'd360) ? 9'(ang_sum - 10'd360) : ang_sum[8:0];
    fold_neg = 1'b0;
    if (ang_new > 9'd270) fold = 10'(signed'({1'b0, ang_new})) - 10'sd360;
    else if (ang_new > 9'd90) begin
      fold = 10'(signed'({1'b0, ang_new})) - 10'sd180;
      fold_neg = 1'b1;
    end else fold = 10'(signed'({1'b0, ang_new}));
  end

  // One CORDIC rotation
  assign shx = cx_r >>> ci_r;
  assign shy = cy_r >>> ci_r;
  assign at  = atan_lut(ci_r);

  // Target with saturation
  always_comb begin
    logic signed [56:0] rcr, rsr;
    logic signed [35:0] sx, sy;
    rcr  = rc_r + 57'sd536870912;
    rsr  = rs_r + 57'sd536870912;
    sx = 36'(rcr >>> 30) - 36'(signed'({1'b0, radius_r})) + 36'(anchor_x_r);
    sy = 36'(rsr >>> 30) + 36'(anchor_y_r);
    tx_w = (sx > 36'sd2147483647) ? 35'sd2147483647 :
           (sx < -36'sd2147483648) ? -35'sd2147483648 : 35'(sx);
    ty_w = (sy > 36'sd2147483647) ? 35'sd2147483647 :
           (sy < -36'sd2147483648) ? -35'sd2147483648 : 35'(sy);
  end

  assign mmax = (mx_r > my_r) ? mx_r : my_r;
  assign sq_trial = sq_res_r + sq_bit_r;

  // Restoring division step, both lanes
  assign rx_t = {rx_r, nx_r[52]};
  assign ry_t = {ry_r, ny_r[52]};

  // Sign and clamp
  always_comb begin
    logic signed [22:0] qx, qy;
    qx = 23'(signed'({1'b0, nx_r[21:0]}));
    qy = 23'(signed'({1'b0, ny_r[21:0]}));
    if (|nx_r[52:22]) qx = 23'sd2097151;
    if (|ny_r[52:22]) qy = 23'sd2097151;
    if (dx_r[32] != sp_s[20]) qx = -qx;
    if (dy_r[32] != sp_s[20]) qy = -qy;
    vx_w = (qx > 23'sd1048575) ? 23'sd1048575 : (qx < -23'sd1048576) ? -23'sd1048576 : qx;
    vy_w = (qy > 23'sd1048575) ? 23'sd1048575 : (qy < -23'sd1048576) ? -23'sd1048576 : qy;
  end

  assign sts.adv       = adv_c;
  assign sts.degen     = degen_r;
  assign sts.norm_done = mmax[32:31] == 2'b00 && mmax[30];

  // Configuration and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= 23'd65536;
      step_r     <= 7'd5;
      speed_r    <= 21'd13107;
      reach_r    <= 20'd13107;
      anchor_x_r <= '0;
      anchor_y_r <= '0;
      target_x_r <= '0;
      target_y_r <= '0;
      angle_r    <= '0;
      anchored_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_RADIUS: radius_r <= cfg_wdata[22:0];
          REG_STEP:   step_r   <= cfg_wdata[6:0];
          REG_SPEED:  speed_r  <= cfg_wdata[20:0];
          REG_REACH:  reach_r  <= cfg_wdata[19:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_REACH && (!anchored_r || restart_r)) begin
        anchor_x_r <= px_r;
        anchor_y_r <= py_r;
        anchored_r <= 1'b1;
      end
      if (cmd.op == OP_ANGLE) angle_r <= ang_new;
      if (cmd.op == OP_TARGET) begin
        target_x_r <= 32'(tx_w);
        target_y_r <= 32'(ty_w);
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        px_r      <= in_pos_x;
        py_r      <= in_pos_y;
        restart_r <= in_restart;
      end
      OP_ANGLE: begin
        cx_r   <= 34'(CordicGainQ30);
        cy_r   <= '0;
        cz_r   <= 25'(fold) * 25'sd65536;
        cneg_r <= fold_neg;
        ci_r   <= '0;
      end
      OP_CORDIC: begin
        if (!cz_r[24]) begin
          cx_r <= cx_r - shy;
          cy_r <= cy_r + shx;
          cz_r <= cz_r - 25'(at);
        end else begin
          cx_r <= cx_r + shy;
          cy_r <= cy_r - shx;
          cz_r <= cz_r + 25'(at);
        end
        ci_r <= ci_r + 5'd1;
      end
      OP_RMUL: begin
        rc_r <= 57'(signed'({1'b0, radius_r})) * 57'(cneg_r ? -cx_r : cx_r);
        rs_r <= 57'(signed'({1'b0, radius_r})) * 57'(cneg_r ? -cy_r : cy_r);
      end
      OP_DIFF: begin
        logic signed [32:0] ex, ey;
        ex = 33'(target_x_r) - 33'(px_r);
        ey = 33'(target_y_r) - 33'(py_r);
        dx_r    <= ex;
        dy_r    <= ey;
        mx_r    <= ex[32] ? 33'(-ex) : 33'(ex);
        my_r    <= ey[32] ? 33'(-ey) : 33'(ey);
        degen_r <= (ex == '0) && (ey == '0);
      end
      OP_NORM: begin
        if (mmax[32:31] != 2'b00) begin
          mx_r <= mx_r >> 1;
          my_r <= my_r >> 1;
        end else begin
          mx_r <= mx_r << 1;
          my_r <= my_r << 1;
        end
      end
      OP_SQSUM: begin
        sq_v_r   <= 64'(mx_r[30:0]) * 64'(mx_r[30:0]) + 64'(my_r[30:0]) * 64'(my_r[30:0]);
        sq_res_r <= '0;
        sq_bit_r <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT: begin
        if (sq_v_r >= sq_trial) begin
          sq_v_r   <= sq_v_r - sq_trial;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else sq_res_r <= sq_res_r >> 1;
        sq_bit_r <= sq_bit_r >> 2;
      end
      OP_NUM: begin
        len_r <= sq_res_r[31:0];
        nx_r  <= 53'(mx_r[30:0]) * 53'(spm) + 53'(sq_res_r[31:1]);
        ny_r  <= 53'(my_r[30:0]) * 53'(spm) + 53'(sq_res_r[31:1]);
        rx_r  <= '0;
        ry_r  <= '0;
      end
      OP_DIV: begin
        if (rx_t >= 33'(len_r)) begin
          rx_r <= 32'(rx_t - 33'(len_r));
          nx_r <= {nx_r[51:0], 1'b1};
        end else begin
          rx_r <= rx_t[31:0];
          nx_r <= {nx_r[51:0], 1'b0};
        end
        if (ry_t >= 33'(len_r)) begin
          ry_r <= 32'(ry_t - 33'(len_r));
          ny_r <= {ny_r[51:0], 1'b1};
        end else begin
          ry_r <= ry_t[31:0];
          ny_r <= {ny_r[51:0], 1'b0};
        end
      end
      OP_FINISH: begin
        out_vel_x      <= degen_r ? '0 : 21'(vx_w);
        out_vel_y      <= degen_r ? '0 : 21'(vy_w);
        out_angle_deg  <= angle_r;
        out_advanced   <= cmd.do_adv;
        out_degenerate <= degen_r;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### rtl/circle_waypoint_velocity_guide.sv
// Top level: circle waypoint velocity guide
//
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | in_pos_x, in_pos_y, in_restart
// out     | output    | out_valid / out_ready  | out_vel_x, out_vel_y, out_angle_deg,
//         |           |                        | out_advanced, out_degenerate
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// From accept to result register an item passes through the reach test, difference,
// up to 30 normalizing shifts plus one check, 32 square root steps and 53 divider steps.
// A moved waypoint adds setup, 18 CORDIC rotations, multiply and target; a zero
// difference vector skips normalizing, square root and divide and ends after the check.
// The next item is taken in the cycle after its result is loaded; reset is synchronous,
// active low, and configuration writes are always taken.
// A stalled output holds its result; the block then waits before its final step.
`default_nettype none
module circle_waypoint_velocity_guide import cwvg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic        in_restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [20:0]      out_vel_x,
  output logic [20:0]      out_vel_y,
  output logic [8:0]       out_angle_deg,
  output logic             out_advanced,
  output logic             out_degenerate,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cwvg_cmd_t cmd;
  cwvg_sts_t sts;

  assign cfg_ready = 1'b1;

  cwvg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cwvg_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_valid),
    .cfg_idx        (cfg_index),
    .cfg_wdata      (cfg_data),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_restart     (in_restart),
    .out_vel_x      (out_vel_x),
    .out_vel_y      (out_vel_y),
    .out_angle_deg  (out_angle_deg),
    .out_advanced   (out_advanced),
    .out_degenerate (out_degenerate)
  );

endmodule
`default_nettype wire

### verif/circle_waypoint_velocity_guide_tb.sv
// Testbench for the circle waypoint velocity guide: scoreboard prediction, random stimulus
`timescale 1ns / 100ps
module circle_waypoint_velocity_guide_tb import cwvg_pkg::*;;

  localparam int CycleLimit = 2000000;
  localparam longint VelMax = 1048575;
  localparam longint VelMin = -1048576;

  typedef struct {
    logic [20:0] vel_x;
    logic [20:0] vel_y;
    logic [8:0]  angle;
    logic        adv;
    logic        degen;
  } guide_result_t;

  // Model of the guide: circle state, settings and pending results
  class guide_scoreboard;
    longint unsigned radius, step, reach;
    logic [20:0] speed;
    longint anchor_x, anchor_y, tgt_x, tgt_y;
    int unsigned angle;
    bit anchored;
    guide_result_t pending[$];
    int mismatches;

    function new();
      radius = 65536;
      step = 5;
      speed = 21'd13107;
      reach = 13107;
      anchor_x = 0;
      anchor_y = 0;
      tgt_x = 0;
      tgt_y = 0;
      angle = 0;
      anchored = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_RADIUS: radius = val[22:0];
        REG_STEP:   step = val[6:0];
        REG_SPEED:  speed = val[20:0];
        REG_REACH:  reach = val[19:0];
        default: ;
      endcase
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Fold to -90..90, then rotate in Q30 with 2^-16 degree angle units
    function void rotate(int unsigned deg, output longint c, output longint s);
      longint a, x, y, z, nx;
      bit neg;
      a = deg;
      neg = 0;
      x = CordicGainQ30;
      y = 0;
      if (a > 270) a -= 360;
      else if (a > 90) begin
        a -= 180;
        neg = 1;
      end
      z = a * 65536;
      for (int i = 0; i < CordicSteps; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(atan_lut(i[4:0]));
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(atan_lut(i[4:0]));
        end
        x = nx;
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function logic [20:0] scale(longint unsigned m, bit negd, longint unsigned spm, bit negsp,
                                longint unsigned len);
      longint q;
      q = longint'((m * spm + (len >> 1)) / len);
      if (negd != negsp) q = -q;
      if (q > VelMax) q = VelMax;
      if (q < VelMin) q = VelMin;
      return q[20:0];
    endfunction

    // Advance the circle state for one accepted tick and queue its result
    function void note_tick(logic [31:0] px_in, logic [31:0] py_in, logic rs);
      longint px, py, dx, dy, c, s, r, sp;
      longint unsigned ax, ay, mx, my, spm, len;
      guide_result_t res;
      px = longint'($signed(px_in));
      py = longint'($signed(py_in));
      res.adv = 0;
      res.degen = 0;
      res.vel_x = 0;
      res.vel_y = 0;
      if (!anchored || rs) begin
        anchor_x = px;
        anchor_y = py;
        anchored = 1;
        res.adv = 1;
      end else begin
        dx = px - tgt_x;
        dy = py - tgt_y;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax < reach && ay < reach && ax * ax + ay * ay < reach * reach) res.adv = 1;
      end
      if (res.adv) begin
        angle += step;
        if (angle > 360) angle -= 360;
        rotate(angle, c, s);
        r = radius;
        tgt_x = sat32(((r * c + (64'sd1 << 29)) >>> 30) - r + anchor_x);
        tgt_y = sat32(((r * s + (64'sd1 << 29)) >>> 30) + anchor_y);
      end
      dx = tgt_x - px;
      dy = tgt_y - py;
      if (dx == 0 && dy == 0) begin
        res.degen = 1;
      end else begin
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        sp = longint'($signed(speed));
        spm = sp < 0 ? -sp : sp;
        while ((mx > my ? mx : my) >= (64'd1 << 31)) begin
          mx >>= 1;
          my >>= 1;
        end
        while ((mx > my ? mx : my) < (64'd1 << 30)) begin
          mx <<= 1;
          my <<= 1;
        end
        len = root_floor(mx * mx + my * my);
        res.vel_x = scale(mx, dx < 0, spm, sp < 0, len);
        res.vel_y = scale(my, dy < 0, spm, sp < 0, len);
      end
      res.angle = angle[8:0];
      pending.push_back(res);
    endfunction

    function void check_result(guide_result_t got);
      guide_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result vel %0d,%0d angle %0d",
                                       $signed(got.vel_x), $signed(got.vel_y), got.angle);
        return;
      end
      want = pending.pop_front();
      if (got.vel_x !== want.vel_x || got.vel_y !== want.vel_y || got.angle !== want.angle ||
          got.adv !== want.adv || got.degen !== want.degen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected vel %0d,%0d ang %0d adv %0b deg %0b, got %0d,%0d %0d %0b %0b",
                   $signed(want.vel_x), $signed(want.vel_y), want.angle, want.adv, want.degen,
                   $signed(got.vel_x), $signed(got.vel_y), got.angle, got.adv, got.degen);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic [31:0] in_pos_x = 0;
  logic [31:0] in_pos_y = 0;
  logic in_restart = 0;
  logic out_ready = 0;
  logic cfg_valid = 0;
  logic [1:0] cfg_index = REG_RADIUS;
  logic [31:0] cfg_data = 0;
  wire in_ready, out_valid, cfg_ready, out_advanced, out_degenerate;
  wire [20:0] out_vel_x, out_vel_y;
  wire [8:0] out_angle_deg;

  int send_idle = 0;
  int recv_stall = 0;
  int cycles = 0;
  guide_scoreboard sb = new();

  circle_waypoint_velocity_guide uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_restart(in_restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y), .out_angle_deg(out_angle_deg),
    .out_advanced(out_advanced), .out_degenerate(out_degenerate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Stall the result channel at the current rate
  always @(negedge clk) out_ready = ($urandom_range(99) >= recv_stall);

  // Watch both channels and stop on a runaway run
  always @(posedge clk) begin
    guide_result_t got;
    cycles++;
    if (rst_n && in_valid && in_ready) sb.note_tick(in_pos_x, in_pos_y, in_restart);
    if (rst_n && out_valid && out_ready) begin
      got.vel_x = out_vel_x;
      got.vel_y = out_vel_y;
      got.angle = out_angle_deg;
      got.adv = out_advanced;
      got.degen = out_degenerate;
      sb.check_result(got);
    end
    if (cycles >= CycleLimit) begin
      $display("circle_waypoint_velocity_guide_tb: FAIL");
      $finish;
    end
  end

  task automatic send_tick(logic [31:0] x, logic [31:0] y, logic rs);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_pos_x = x;
    in_pos_y = y;
    in_restart = rs;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender until every pending result has drained
  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic apply_settings(logic [22:0] rad, logic [6:0] stp, logic [20:0] spd,
                                logic [19:0] rch);
    drain();
    write_reg(REG_RADIUS, {9'd0, rad});
    write_reg(REG_STEP, {25'd0, stp});
    write_reg(REG_SPEED, {11'd0, spd});
    write_reg(REG_REACH, {12'd0, rch});
  endtask

  function automatic logic [31:0] clip32(longint v);
    longint w;
    w = sb.sat32(v);
    return w[31:0];
  endfunction

  // Mostly ticks that chase the waypoint, some far off and some pure noise
  task automatic random_tick();
    int mode;
    longint h, ox, oy;
    mode = $urandom_range(99);
    h = sb.reach > 2 ? sb.reach / 2 : 0;
    ox = longint'($urandom_range(2 * h)) - h;
    oy = longint'($urandom_range(2 * h)) - h;
    if (mode < 55) send_tick(clip32(sb.tgt_x + ox), clip32(sb.tgt_y + oy), $urandom_range(99) < 5);
    else if (mode < 68) send_tick(clip32(sb.tgt_x), clip32(sb.tgt_y), $urandom_range(99) < 5);
    else if (mode < 85)
      send_tick(clip32(sb.tgt_x + longint'($urandom_range(2097152)) - 1048576),
                clip32(sb.tgt_y + longint'($urandom_range(2097152)) - 1048576),
                $urandom_range(99) < 5);
    else send_tick($urandom, $urandom, $urandom_range(1));
  endtask

  task automatic random_settings();
    logic [22:0] rad;
    logic [6:0] stp;
    logic [20:0] spd;
    logic [19:0] rch;
    rad = ($urandom_range(3) == 0) ? 23'($urandom) : 23'($urandom_range(6553600, 65536));
    stp = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(90, 1));
    spd = ($urandom_range(3) == 0) ? 21'($urandom) : 21'($urandom_range(1310720) - 655360);
    rch = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(655360));
    apply_settings(rad, stp, spd, rch);
  endtask

  initial begin
    int idle_tab[4][2];
    idle_tab = '{'{0, 0}, '{64, 0}, '{0, 64}, '{20, 20}};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: defaults, anchoring, exact waypoint hits, position extremes
    apply_settings(23'd65536, 7'd5, 21'd13107, 20'd13107);
    send_tick(32'd0, 32'd0, 1'b0);
    send_tick(clip32(sb.tgt_x), clip32(sb.tgt_y), 1'b0);
    send_tick(clip32(sb.tgt_x + 100), clip32(sb.tgt_y - 100), 1'b0);
    send_tick(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
    send_tick(32'h80000000, 32'h80000000, 1'b0);
    send_tick(32'h7FFFFFFF, 32'h80000000, 1'b1);
    send_tick(32'h80000000, 32'h7FFFFFFF, 1'b1);
    send_tick(32'hFFFFFFFF, 32'h00000001, 1'b1);
    apply_settings(23'd6553600, 7'd90, -21'sd655360, 20'd655360);
    for (int i = 0; i < 5; i++) send_tick(clip32(sb.tgt_x), clip32(sb.tgt_y), i == 0);
    // Zero reach: sitting on the waypoint never advances and yields zero velocity
    apply_settings(23'd65536, 7'd1, 21'd655360, 20'd0);
    send_tick(32'd12345, 32'd54321, 1'b1);
    send_tick(clip32(sb.tgt_x), clip32(sb.tgt_y), 1'b0);
    // Zero radius: the waypoint lands on the anchor itself
    apply_settings(23'd0, 7'd0, 21'h100000, 20'hFFFFF);
    send_tick(32'h00010000, 32'hFFFF0000, 1'b1);
    send_tick(32'h00010001, 32'hFFFF0000, 1'b0);
    // Largest reach: both offsets just inside it on each axis, but not within the circle
    send_tick(32'h00010000 + 32'h000FFFFE, 32'hFFFF0000 + 32'h000FFFFE, 1'b0);
    apply_settings(23'h7FFFFF, 7'h7F, 21'h0FFFFF, 20'hFFFFF);
    for (int i = 0; i < 4; i++) send_tick(clip32(sb.tgt_x), clip32(sb.tgt_y), i == 0);

    // Random: four idle phases, settings changed between blocks
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_tab[ph][0];
      recv_stall = idle_tab[ph][1];
      for (int blk = 0; blk < 4; blk++) begin
        random_settings();
        for (int i = 0; i < 100; i++) begin
          random_tick();
          if (i == 50 && blk == 0) drain();
        end
      end
    end

    @(negedge clk);
    in_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("circle_waypoint_velocity_guide_tb: PASS");
    end else begin
      $display("circle_waypoint_velocity_guide_tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/cwvg_pkg.sv
rtl/cwvg_ctrl.sv
rtl/cwvg_dp.sv
rtl/circle_waypoint_velocity_guide.sv
verif/circle_waypoint_velocity_guide_tb.sv
